@@ src/ffla_pkg.sv @@
// shared constants and types for the frame free list allocator
package ffla_pkg;

  localparam int unsigned MAX_FRAMES_DEF = 4096;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned PAGE_W   = 8;
  localparam int unsigned FRAME_W  = 13;
  localparam int unsigned GRANT_W  = 12;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_W    = 13;

  localparam logic [CFG_W-1:0] TOTAL_RST    = CFG_W'(4096);
  localparam logic [CFG_W-1:0] RESERVED_RST = '0;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_EMPTY     = 3'd1,
    STS_BAD_COUNT = 3'd2,
    STS_INIT_FAIL = 3'd3,
    STS_IGNORED   = 3'd4,
    STS_NOT_READY = 3'd5
  } status_e;

  typedef enum logic {
    REG_TOTAL    = 1'b0,
    REG_RESERVED = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EXEC
  } state_e;

endpackage

@@ src/ffla_frame_ram.sv @@
// frame table memory: one write port, one read port with registered data
module ffla_frame_ram #(
  parameter int unsigned DEPTH = ffla_pkg::MAX_FRAMES_DEF,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 14
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/frame_free_list_allocator_top.sv @@
// frame free list allocator: sequencer, list head and result register
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------------------
//   in      | input     | in_valid_i/in_ready_o   | operation_i, page_count_i, freed_frame_i
//   out     | output    | out_valid_o/out_ready_i | granted_frame_o, status_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// allocate and free: the accept cycle reads the frame table,
// the execute state checks the entry, writes it back and loads the result
// initialize sweeps one frame a cycle; a failed one skips the sweep
// a full result register holds the commit cycle until the result is taken
// reset clears control state only; initialize rebuilds the table, so no clearing pass
module frame_free_list_allocator_top #(
  parameter int unsigned MAX_FRAMES = ffla_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input transactions
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ffla_pkg::OP_W-1:0]     operation_i,
  input  logic [ffla_pkg::PAGE_W-1:0]   page_count_i,
  input  logic [ffla_pkg::FRAME_W-1:0]  freed_frame_i,
  // result transactions
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ffla_pkg::GRANT_W-1:0]  granted_frame_o,
  output logic [ffla_pkg::STATUS_W-1:0] status_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [ffla_pkg::CFG_W-1:0]    cfg_data_i
);

  // index width, link/count width (holds MAX_FRAMES itself), compare width
  localparam int unsigned IW = $clog2(MAX_FRAMES);
  localparam int unsigned LW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CW = (LW > ffla_pkg::CFG_W) ? LW : ffla_pkg::CFG_W;
  localparam int unsigned FX = (IW > ffla_pkg::FRAME_W) ? IW : ffla_pkg::FRAME_W;
  localparam int unsigned GX = (LW > ffla_pkg::GRANT_W) ? LW : ffla_pkg::GRANT_W;
  // table word: in-use flag on top of the next link
  localparam int unsigned DW = LW + 1;
  localparam logic [CW-1:0] MAX_CW = CW'(MAX_FRAMES);

  ffla_pkg::state_e state_q, state_d;

  // configuration registers
  logic [ffla_pkg::CFG_W-1:0] total_q, reserved_q;

  // list state
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] managed_q, managed_d;
  logic          ready_q, ready_d;

  // captured transaction and initialize bookkeeping
  logic [ffla_pkg::OP_W-1:0]    op_q, op_d;
  logic [ffla_pkg::PAGE_W-1:0]  pages_q, pages_d;
  logic [ffla_pkg::FRAME_W-1:0] idx_q, idx_d;
  logic [LW-1:0]                cnt_q, cnt_d;
  logic [ffla_pkg::CFG_W-1:0]   resv_q, resv_d;
  logic                         init_ok_q, init_ok_d;
  logic [IW-1:0]                swp_q, swp_d;

  // result register
  logic                          out_valid_q, out_valid_d;
  logic [ffla_pkg::GRANT_W-1:0]  granted_q, granted_d;
  logic [ffla_pkg::STATUS_W-1:0] status_q, status_d;

  // table port
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic          rd_in_use;
  logic [LW-1:0] rd_link;

  // helpers
  logic [CW-1:0] total_x, eff_cnt;
  logic          resv_ok;
  logic [FX-1:0] freed_x, idx_x;
  logic [GX-1:0] head_gx;
  logic [LW-1:0] swp_next;
  logic          slot_free;

  assign rd_in_use = ram_rdata[DW-1];
  assign rd_link   = ram_rdata[LW-1:0];

  // effective frame count saturates at the table depth
  assign total_x = CW'(total_q);
  assign eff_cnt = (total_x > MAX_CW) ? MAX_CW : total_x;
  assign resv_ok = CW'(reserved_q) < eff_cnt;

  assign freed_x  = FX'(freed_frame_i);
  assign idx_x    = FX'(idx_q);
  assign head_gx  = GX'(head_q);
  assign swp_next = LW'(swp_q) + LW'(1);

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ffla_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign out_valid_o     = out_valid_q;
  assign granted_frame_o = granted_q;
  assign status_o        = status_q;

  ffla_frame_ram #(
    .DEPTH (MAX_FRAMES),
    .AW    (IW),
    .DW    (DW)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= ffla_pkg::TOTAL_RST;
      reserved_q <= ffla_pkg::RESERVED_RST;
    end else if (cfg_valid_i) begin
      unique case (ffla_pkg::reg_idx_e'(cfg_index_i))
        ffla_pkg::REG_TOTAL:    total_q    <= cfg_data_i;
        ffla_pkg::REG_RESERVED: reserved_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    managed_d   = managed_q;
    ready_d     = ready_q;
    op_d        = op_q;
    pages_d     = pages_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    resv_d      = resv_q;
    init_ok_d   = init_ok_q;
    swp_d       = swp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    granted_d   = granted_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      ffla_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = operation_i;
          pages_d = page_count_i;
          idx_d   = freed_frame_i;
          // fetch the entry the commit cycle will look at
          ram_re    = 1'b1;
          ram_raddr = (operation_i == ffla_pkg::OP_ALLOC) ? head_q[IW-1:0] : freed_x[IW-1:0];
          state_d   = ffla_pkg::ST_EXEC;
          if (operation_i == ffla_pkg::OP_INIT) begin
            cnt_d     = LW'(eff_cnt);
            resv_d    = reserved_q;
            init_ok_d = 1'b0;
            swp_d     = '0;
            if (resv_ok) begin
              state_d = ffla_pkg::ST_SWEEP;
            end
          end
        end
      end

      ffla_pkg::ST_SWEEP: begin
        // one frame a cycle: used flag below the reserved bound, link to the next
        ram_we    = 1'b1;
        ram_waddr = swp_q;
        ram_wdata = {(CW'(swp_q) < CW'(resv_q)), swp_next};
        if (swp_next == cnt_q) begin
          init_ok_d = 1'b1;
          state_d   = ffla_pkg::ST_EXEC;
        end else begin
          swp_d = swp_q + IW'(1);
        end
      end

      ffla_pkg::ST_EXEC: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          granted_d   = '0;
          state_d     = ffla_pkg::ST_IDLE;
          unique case (op_q)
            ffla_pkg::OP_INIT: begin
              if (init_ok_q) begin
                status_d  = ffla_pkg::STS_OK;
                ready_d   = 1'b1;
                managed_d = cnt_q;
                head_d    = LW'(resv_q);
              end else begin
                status_d = ffla_pkg::STS_INIT_FAIL;
                ready_d  = 1'b0;
              end
            end
            ffla_pkg::OP_ALLOC: begin
              if (!ready_q) begin
                status_d = ffla_pkg::STS_NOT_READY;
              end else if (pages_q != ffla_pkg::PAGE_W'(1)) begin
                status_d = ffla_pkg::STS_BAD_COUNT;
              end else if (head_q >= managed_q) begin
                status_d = ffla_pkg::STS_EMPTY;
              end else begin
                // pop the head and mark it used
                status_d  = ffla_pkg::STS_OK;
                granted_d = head_gx[ffla_pkg::GRANT_W-1:0];
                head_d    = rd_link;
                ram_we    = 1'b1;
                ram_waddr = head_q[IW-1:0];
                ram_wdata = {1'b1, rd_link};
              end
            end
            ffla_pkg::OP_FREE: begin
              if (!ready_q) begin
                status_d = ffla_pkg::STS_NOT_READY;
              end else if (CW'(idx_q) >= CW'(managed_q) || !rd_in_use) begin
                status_d = ffla_pkg::STS_IGNORED;
              end else begin
                // push the frame onto the head
                status_d  = ffla_pkg::STS_OK;
                head_d    = LW'(idx_q);
                ram_we    = 1'b1;
                ram_waddr = idx_x[IW-1:0];
                ram_wdata = {1'b0, head_q};
              end
            end
            default: begin
              status_d = ffla_pkg::STS_IGNORED;
            end
          endcase
        end
      end

      default: begin
        state_d = ffla_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffla_pkg::ST_IDLE;
      head_q      <= '0;
      managed_q   <= '0;
      ready_q     <= 1'b0;
      init_ok_q   <= 1'b0;
      swp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      managed_q   <= managed_d;
      ready_q     <= ready_d;
      init_ok_q   <= init_ok_d;
      swp_q       <= swp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    pages_q   <= pages_d;
    idx_q     <= idx_d;
    cnt_q     <= cnt_d;
    resv_q    <= resv_d;
    granted_q <= granted_d;
    status_q  <= status_d;
  end

endmodule
